// ===== src/psh_pkg.sv =====
package psh_pkg;

  // Default size of the log2 and exp2 tables, as index bits.
  localparam int unsigned POW_TABLE_BITS = 8;

  // Field and datapath widths.
  localparam int unsigned NRM_W   = 16;  // Q1.14 normal and light components
  localparam int unsigned PNT_W   = 21;  // Q12.8 positions
  localparam int unsigned EYE_W   = 22;  // point-to-eye components
  localparam int unsigned DRAW_W  = 35;  // negated normal-light dot, Q2.28
  localparam int unsigned DFAC_W  = 15;  // clamped diffuse factor, 0..1.0 in Q.14
  localparam int unsigned REF_W   = 19;  // reflection vector components
  localparam int unsigned SQR_W   = 43;  // one squared eye component
  localparam int unsigned SQS_W   = 44;  // squared eye length
  localparam int unsigned ROOT_W  = 22;  // eye length
  localparam int unsigned DOT_W   = 43;  // signed reflection-eye dot
  localparam int unsigned DOTM_W  = 42;  // positive part of that dot
  localparam int unsigned QUO_W   = 15;  // specular base and power, 0..1.0 in Q.14
  localparam int unsigned REM_W   = 37;  // divider remainder
  localparam int unsigned LG_W    = 20;  // negated log2, Q.16
  localparam int unsigned SHIN_W  = 16;  // shininess, Q8.8
  localparam int unsigned PROD_W  = 28;  // log2 times exponent, Q.16
  localparam int unsigned EXP_W   = 31;  // exp2 table entries, Q.30
  localparam int unsigned TERM_W  = 16;  // color terms, Q2.14
  localparam int unsigned SUM_W   = 18;  // summed channel before scaling
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned NCH     = 4;
  localparam int unsigned ONE_Q14 = 16384;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT     = 3'd0,
    REG_CAMERA    = 3'd1,
    REG_AMBIENT   = 3'd2,
    REG_DIFFUSE   = 3'd3,
    REG_SPECULAR  = 3'd4,
    REG_SHININESS = 3'd5
  } cfg_reg_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [3*NRM_W-1:0]  light;
    logic [3*PNT_W-1:0]  camera;
    logic [NCH*TERM_W-1:0] ambient;
    logic [NCH*TERM_W-1:0] diffuse;
    logic [NCH*TERM_W-1:0] specular;
    logic [SHIN_W-1:0]   shininess;
  } cfg_t;

  // Per-item flags that travel alongside the datapath.
  typedef struct packed {
    logic              missed;
    logic              spec;   // specular term applies
    logic [DFAC_W-1:0] dfac;
  } side_t;

  // Floor square root, used when the tables are built.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    rem = v;
    bt  = 64'h4000_0000_0000_0000;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // One log2 table entry, Q.16, by repeated squaring of the mantissa.
  function automatic logic [15:0] log_entry(input int bits, input int idx);
    logic [63:0] m;
    logic [15:0] res;
    m   = (64'd1 << 30) + (64'(idx) << (30 - bits));
    res = '0;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m      = m >> 1;
        res[b] = 1'b1;
      end
    end
    return res;
  endfunction

  // Step ratio of the exp2 table, 2^(-1/2^bits) in Q.32.
  function automatic logic [63:0] exp_root(input int bits);
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int i = 0; i < bits; i++) root = isqrt64(root << 32);
    return root;
  endfunction

endpackage

// ===== src/psh_geom.sv =====
module psh_geom (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                missed_i,
  input  logic [2:0][psh_pkg::NRM_W-1:0]      nrm_i,
  input  logic [2:0][psh_pkg::PNT_W-1:0]      pnt_i,
  input  psh_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  output psh_pkg::side_t                      side_o,
  output logic [psh_pkg::DOTM_W-1:0]          dot_o,
  output logic [psh_pkg::SQS_W-1:0]           sq_o
);

  localparam int unsigned NRM_W  = psh_pkg::NRM_W;
  localparam int unsigned PNT_W  = psh_pkg::PNT_W;
  localparam int unsigned EYE_W  = psh_pkg::EYE_W;
  localparam int unsigned DRAW_W = psh_pkg::DRAW_W;
  localparam int unsigned DFAC_W = psh_pkg::DFAC_W;
  localparam int unsigned REF_W  = psh_pkg::REF_W;
  localparam int unsigned SQR_W  = psh_pkg::SQR_W;
  localparam int unsigned SQS_W  = psh_pkg::SQS_W;
  localparam int unsigned DOT_W  = psh_pkg::DOT_W;
  localparam int unsigned DOTM_W = psh_pkg::DOTM_W;

  logic                     va_q, vb_q, vc_q;
  logic                     miss_a_q;
  logic signed [NRM_W-1:0]  nrm_a_q [3];
  logic signed [EYE_W-1:0]  eye_a_d [3];
  logic signed [EYE_W-1:0]  eye_a_q [3];
  logic signed [DRAW_W-1:0] draw_a_d, draw_a_q;

  psh_pkg::side_t           side_b_d, side_b_q;
  logic signed [REF_W-1:0]  refl_b_d [3];
  logic signed [REF_W-1:0]  refl_b_q [3];
  logic signed [EYE_W-1:0]  eye_b_q [3];
  logic [SQR_W-1:0]         sq_b_d [3];
  logic [SQR_W-1:0]         sq_b_q [3];

  psh_pkg::side_t           side_c_d, side_c_q;
  logic [DOTM_W-1:0]        dot_c_d, dot_c_q;
  logic [SQS_W-1:0]         sq_c_d, sq_c_q;

  // First stage: negated normal-light dot and point-to-eye vector.
  always_comb begin : stage_a
    logic signed [2*NRM_W-1:0] prod;
    draw_a_d = '0;
    for (int a = 0; a < 3; a++) begin
      prod = $signed(nrm_i[a]) * $signed(cfg_i.light[a*NRM_W +: NRM_W]);
      draw_a_d = draw_a_d - DRAW_W'(prod);
      eye_a_d[a] = EYE_W'($signed(cfg_i.camera[a*PNT_W +: PNT_W]))
                 - EYE_W'($signed(pnt_i[a]));
    end
  end

  // Second stage: clamp the diffuse factor, form the reflection vector and squares.
  always_comb begin : stage_b
    logic signed [DRAW_W-1:0]  dsh;
    logic signed [2*NRM_W-1:0] prod;
    logic signed [2*EYE_W-1:0] sqf;
    side_b_d.missed = miss_a_q;
    side_b_d.spec   = draw_a_q > 0;
    dsh = draw_a_q >>> 14;
    if (!side_b_d.spec) begin
      side_b_d.dfac = '0;
    end else if (dsh > DRAW_W'(psh_pkg::ONE_Q14)) begin
      side_b_d.dfac = DFAC_W'(psh_pkg::ONE_Q14);
    end else begin
      side_b_d.dfac = dsh[DFAC_W-1:0];
    end
    for (int a = 0; a < 3; a++) begin
      // 2 * dfac * n floored by 14 bits is dfac * n floored by 13 bits.
      prod = $signed({1'b0, side_b_d.dfac}) * nrm_a_q[a];
      refl_b_d[a] = REF_W'(prod >>> 13)
                  + REF_W'($signed(cfg_i.light[a*NRM_W +: NRM_W]));
      sqf = eye_a_q[a] * eye_a_q[a];
      sq_b_d[a] = sqf[SQR_W-1:0];
    end
  end

  // Third stage: reflection-eye dot and squared eye length.
  always_comb begin : stage_c
    logic signed [DOT_W-1:0] prod;
    logic signed [DOT_W-1:0] acc;
    logic [SQS_W-1:0]        sacc;
    acc  = '0;
    sacc = '0;
    for (int a = 0; a < 3; a++) begin
      prod = DOT_W'(refl_b_q[a]) * DOT_W'(eye_b_q[a]);
      acc  = acc + prod;
      sacc = sacc + SQS_W'(sq_b_q[a]);
    end
    side_c_d      = side_b_q;
    side_c_d.spec = side_b_q.spec && (acc > 0);
    dot_c_d       = acc[DOTM_W-1:0];
    sq_c_d        = sacc;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      miss_a_q <= missed_i;
      draw_a_q <= draw_a_d;
      side_b_q <= side_b_d;
      side_c_q <= side_c_d;
      dot_c_q  <= dot_c_d;
      sq_c_q   <= sq_c_d;
      for (int a = 0; a < 3; a++) begin
        nrm_a_q[a]  <= $signed(nrm_i[a]);
        eye_a_q[a]  <= eye_a_d[a];
        refl_b_q[a] <= refl_b_d[a];
        eye_b_q[a]  <= eye_a_q[a];
        sq_b_q[a]   <= sq_b_d[a];
      end
    end
  end

  assign valid_o = vc_q;
  assign side_o  = side_c_q;
  assign dot_o   = dot_c_q;
  assign sq_o    = sq_c_q;

endmodule

// ===== src/psh_sqrt.sv =====
module psh_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  psh_pkg::side_t               side_i,
  input  logic [psh_pkg::DOTM_W-1:0]   dot_i,
  input  logic [psh_pkg::SQS_W-1:0]    sq_i,
  output logic                         valid_o,
  output psh_pkg::side_t               side_o,
  output logic [psh_pkg::DOTM_W-1:0]   dot_o,
  output logic [psh_pkg::ROOT_W-1:0]   root_o
);

  localparam int unsigned SQS_W  = psh_pkg::SQS_W;
  localparam int unsigned ROOT_W = psh_pkg::ROOT_W;
  localparam int unsigned DOTM_W = psh_pkg::DOTM_W;
  localparam int unsigned STEPS  = 2;
  localparam int unsigned NSTG   = (ROOT_W + STEPS - 1) / STEPS;
  localparam int unsigned WIDE_W = SQS_W + 2;

  logic                v_q    [NSTG];
  psh_pkg::side_t      side_q [NSTG];
  logic [DOTM_W-1:0]   dot_q  [NSTG];
  logic [SQS_W-1:0]    rem_q  [NSTG];
  logic [ROOT_W-1:0]   root_q [NSTG];

  // Digit-by-digit square root, two result bits per stage, top bit first.
  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    logic              v_in;
    psh_pkg::side_t    side_in;
    logic [DOTM_W-1:0] dot_in;
    logic [SQS_W-1:0]  rem_in, rem_d;
    logic [ROOT_W-1:0] root_in, root_d;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign dot_in  = dot_i;
      assign rem_in  = sq_i;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign side_in = side_q[g-1];
      assign dot_in  = dot_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    // Raising the root by 2^i adds (root << (i+1)) + 4^i to its square.
    always_comb begin
      logic [WIDE_W-1:0] delta;
      int                bi;
      rem_d  = rem_in;
      root_d = root_in;
      for (int j = 0; j < STEPS; j++) begin
        bi = ROOT_W - 1 - (g * STEPS + j);
        if (bi >= 0) begin
          delta = (WIDE_W'(root_d) << (bi + 1)) + (WIDE_W'(1) << (2 * bi));
          if (WIDE_W'(rem_d) >= delta) begin
            rem_d  = rem_d - SQS_W'(delta);
            root_d = root_d | (ROOT_W'(1) << bi);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g] <= side_in;
        dot_q[g]  <= dot_in;
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
      end
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];
  assign dot_o   = dot_q[NSTG-1];
  assign root_o  = root_q[NSTG-1];

endmodule

// ===== src/psh_div.sv =====
module psh_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  psh_pkg::side_t               side_i,
  input  logic [psh_pkg::DOTM_W-1:0]   dot_i,
  input  logic [psh_pkg::ROOT_W-1:0]   root_i,
  output logic                         valid_o,
  output psh_pkg::side_t               side_o,
  output logic [psh_pkg::QUO_W-1:0]    quo_o
);

  localparam int unsigned DOTM_W = psh_pkg::DOTM_W;
  localparam int unsigned ROOT_W = psh_pkg::ROOT_W;
  localparam int unsigned QUO_W  = psh_pkg::QUO_W;
  localparam int unsigned REM_W  = psh_pkg::REM_W;
  localparam int unsigned STEPS  = 2;
  localparam int unsigned NSTG   = (QUO_W + STEPS - 1) / STEPS;
  localparam logic [QUO_W-1:0] ONE = QUO_W'(psh_pkg::ONE_Q14);

  logic                pv_q;
  psh_pkg::side_t      pside_d, pside_q;
  logic                pov_q;
  logic [REM_W-1:0]    prem_q;
  logic [ROOT_W-1:0]   proot_q;

  logic                v_q    [NSTG];
  psh_pkg::side_t      side_q [NSTG];
  logic                ov_q   [NSTG];
  logic [REM_W-1:0]    rem_q  [NSTG];
  logic [ROOT_W-1:0]   root_q [NSTG];
  logic [QUO_W-1:0]    quo_q  [NSTG];

  // Entry stage: a quotient of 2^15 or more clamps, and a zero length drops
  // the specular term.
  always_comb begin
    pside_d      = side_i;
    pside_d.spec = side_i.spec && (root_i != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pside_q      <= pside_d;
      pov_q        <= dot_i >= DOTM_W'({root_i, {QUO_W{1'b0}}});
      prem_q       <= dot_i[REM_W-1:0];
      proot_q      <= root_i;
    end
  end

  // Restoring division, two quotient bits per stage.
  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    logic              v_in, ov_in;
    psh_pkg::side_t    side_in;
    logic [REM_W-1:0]  rem_in, rem_d;
    logic [ROOT_W-1:0] root_in;
    logic [QUO_W-1:0]  quo_in, quo_d;

    if (g == 0) begin : g_first
      assign v_in    = pv_q;
      assign side_in = pside_q;
      assign ov_in   = pov_q;
      assign rem_in  = prem_q;
      assign root_in = proot_q;
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign side_in = side_q[g-1];
      assign ov_in   = ov_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign quo_in  = quo_q[g-1];
    end

    always_comb begin
      logic [REM_W-1:0] trial;
      int               bi;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < STEPS; j++) begin
        bi = QUO_W - 1 - (g * STEPS + j);
        if (bi >= 0) begin
          trial = REM_W'(root_in) << bi;
          if (rem_d >= trial) begin
            rem_d     = rem_d - trial;
            quo_d[bi] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g] <= side_in;
        ov_q[g]   <= ov_in;
        rem_q[g]  <= rem_d;
        root_q[g] <= root_in;
        quo_q[g]  <= quo_d;
      end
    end
  end

  // Clamp the base to 1.0.
  assign valid_o = v_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];
  assign quo_o   = (ov_q[NSTG-1] || quo_q[NSTG-1] > ONE) ? ONE : quo_q[NSTG-1];

endmodule

// ===== src/psh_shade.sv =====
module psh_shade #(
  parameter int unsigned POW_TABLE_BITS = psh_pkg::POW_TABLE_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  psh_pkg::side_t                           side_i,
  input  logic [psh_pkg::QUO_W-1:0]                quo_i,
  input  psh_pkg::cfg_t                            cfg_i,
  output logic                                     valid_o,
  output logic [psh_pkg::NCH-1:0][psh_pkg::PIX_W-1:0] pix_o
);

  localparam int unsigned QUO_W    = psh_pkg::QUO_W;
  localparam int unsigned LG_W     = psh_pkg::LG_W;
  localparam int unsigned SHIN_W   = psh_pkg::SHIN_W;
  localparam int unsigned PROD_W   = psh_pkg::PROD_W;
  localparam int unsigned EXP_W    = psh_pkg::EXP_W;
  localparam int unsigned TERM_W   = psh_pkg::TERM_W;
  localparam int unsigned DFAC_W   = psh_pkg::DFAC_W;
  localparam int unsigned SUM_W    = psh_pkg::SUM_W;
  localparam int unsigned PIX_W    = psh_pkg::PIX_W;
  localparam int unsigned NCH      = psh_pkg::NCH;
  localparam int unsigned TAB_SIZE = 1 << POW_TABLE_BITS;
  localparam logic [QUO_W-1:0] ONE = QUO_W'(psh_pkg::ONE_Q14);

  typedef logic [15:0]      log_arr_t [TAB_SIZE];
  typedef logic [EXP_W-1:0] exp_arr_t [TAB_SIZE];

  function automatic log_arr_t build_log();
    log_arr_t t;
    for (int i = 0; i < TAB_SIZE; i++) t[i] = psh_pkg::log_entry(POW_TABLE_BITS, i);
    return t;
  endfunction

  function automatic exp_arr_t build_exp();
    exp_arr_t    t;
    logic [63:0] root;
    logic [63:0] acc;
    root = psh_pkg::exp_root(POW_TABLE_BITS);
    acc  = 64'd1 << 30;
    t[0] = acc[EXP_W-1:0];
    for (int i = 1; i < TAB_SIZE; i++) begin
      acc  = (acc * root) >> 32;
      t[i] = acc[EXP_W-1:0];
    end
    return t;
  endfunction

  localparam log_arr_t LOG_TAB = build_log();
  localparam exp_arr_t EXP_TAB = build_exp();

  logic                 v1_q, v2_q, v3_q, v4_q, v5_q;
  psh_pkg::side_t       side1_q, side2_q, side3_q;
  logic                 miss4_q;

  logic                 sp1_d, sp1_q, sp2_q;
  logic [QUO_W-1:0]     spv1_d, spv1_q, spv2_q;
  logic [LG_W-1:0]      lg1_d, lg1_q;
  logic [PROD_W-1:0]    p2_d, p2_q;
  logic [QUO_W-1:0]     pw3_d, pw3_q;
  logic [SUM_W-1:0]     sum4_d [NCH];
  logic [SUM_W-1:0]     sum4_q [NCH];
  logic [NCH-1:0][PIX_W-1:0] pix5_d, pix5_q;

  // Log2 of the base, or a fixed power for the edge cases.
  always_comb begin : stage_log
    logic [3:0]                msb;
    logic [3:0]                k;
    logic [QUO_W-1:0]          xs;
    logic [POW_TABLE_BITS-1:0] idx;
    msb = '0;
    for (int b = 0; b < 14; b++) begin
      if (quo_i[b]) msb = 4'(b);
    end
    k   = 4'(14 - msb);
    xs  = quo_i << k;
    idx = xs[13 -: POW_TABLE_BITS];
    lg1_d = {k, 16'b0} - LG_W'(LOG_TAB[idx]);
    sp1_d  = 1'b1;
    spv1_d = '0;
    if (!side_i.spec) begin
      spv1_d = '0;
    end else if (quo_i == '0) begin
      spv1_d = (cfg_i.shininess == '0) ? ONE : '0;
    end else if (quo_i >= ONE) begin
      spv1_d = ONE;
    end else begin
      sp1_d = 1'b0;
    end
  end

  // Scale the log by the exponent.
  always_comb begin : stage_mul
    logic [LG_W+SHIN_W-1:0] prod;
    prod = lg1_q * cfg_i.shininess;
    p2_d = prod[LG_W+SHIN_W-1:8];
  end

  // Exp2 by table lookup and a right shift by the integer part.
  always_comb begin : stage_exp
    logic [PROD_W-17:0] q;
    logic [EXP_W-1:0]   ev;
    q  = p2_q[PROD_W-1:16];
    ev = EXP_TAB[p2_q[15 -: POW_TABLE_BITS]] >> 16;
    ev = ev >> q[4:0];
    if (sp2_q) begin
      pw3_d = spv2_q;
    end else if (q >= 31) begin
      pw3_d = '0;
    end else begin
      pw3_d = ev[QUO_W-1:0];
    end
  end

  // Sum ambient, diffuse and specular for each channel.
  always_comb begin : stage_sum
    logic [TERM_W+DFAC_W-1:0] pd;
    logic [TERM_W+QUO_W-1:0]  ps;
    for (int c = 0; c < NCH; c++) begin
      pd = cfg_i.diffuse[c*TERM_W +: TERM_W] * side3_q.dfac;
      ps = cfg_i.specular[c*TERM_W +: TERM_W] * pw3_q;
      sum4_d[c] = SUM_W'(cfg_i.ambient[c*TERM_W +: TERM_W])
                + SUM_W'(pd >> 14) + SUM_W'(ps >> 14);
    end
  end

  // Scale to 0..255 and saturate; a miss gives black.
  always_comb begin : stage_pix
    logic [SUM_W+PIX_W-1:0] sc;
    for (int c = 0; c < NCH; c++) begin
      sc = sum4_q[c] * 8'd255;
      if (miss4_q) begin
        pix5_d[c] = '0;
      end else if (sc[SUM_W+PIX_W-1:14] > 255) begin
        pix5_d[c] = '1;
      end else begin
        pix5_d[c] = sc[14 +: PIX_W];
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      sp1_q   <= sp1_d;
      spv1_q  <= spv1_d;
      lg1_q   <= lg1_d;
      side2_q <= side1_q;
      sp2_q   <= sp1_q;
      spv2_q  <= spv1_q;
      p2_q    <= p2_d;
      side3_q <= side2_q;
      pw3_q   <= pw3_d;
      miss4_q <= side3_q.missed;
      for (int c = 0; c < NCH; c++) sum4_q[c] <= sum4_d[c];
      pix5_q  <= pix5_d;
    end
  end

  assign valid_o = v5_q;
  assign pix_o   = pix5_q;

endmodule

// ===== src/phong_pixel_shader.sv =====
// Channel   Direction  Handshake                  Contents
// s_axis    in         s_axis_tvalid/tready       one ray hit
// m_axis    out        m_axis_tvalid/tready       one RGBA pixel
// cfg       in         cfg_valid/cfg_ready        register index and write data
//
// One hit enters every cycle while the output is not stalled; each pixel passes
// through 3 geometry stages, 11 square-root stages, 9 divider stages and 5 shading stages.
// The throughput is set by the pipeline registers alone; no unit is shared.
// When the output register holds a pixel that is not taken, every stage holds
// and s_axis_tready_o drops, so nothing is lost or repeated.
// Reset clears the valid bits and the configuration (shininess comes up as 1.0).
module phong_pixel_shader #(
  parameter int unsigned POW_TABLE_BITS = psh_pkg::POW_TABLE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // normal_x, normal_y, normal_z (16 each), point_x, point_y, point_z (21 each), pad
  input  logic [111:0]                      s_axis_tdata_i,
  // missed
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // red, green, blue, alpha (8 each)
  output logic [31:0]                       m_axis_tdata_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psh_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psh_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned NRM_W = psh_pkg::NRM_W;
  localparam int unsigned PNT_W = psh_pkg::PNT_W;

  psh_pkg::cfg_t                       cfg_q;
  logic                                en;
  logic [2:0][NRM_W-1:0]               nrm;
  logic [2:0][PNT_W-1:0]               pnt;

  logic                                g_valid, s_valid, d_valid;
  psh_pkg::side_t                      g_side, s_side, d_side;
  logic [psh_pkg::DOTM_W-1:0]          g_dot, s_dot;
  logic [psh_pkg::SQS_W-1:0]           g_sq;
  logic [psh_pkg::ROOT_W-1:0]          s_root;
  logic [psh_pkg::QUO_W-1:0]           d_quo;
  logic [psh_pkg::NCH-1:0][psh_pkg::PIX_W-1:0] pix;

  // Configuration registers; a write to an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light     <= '0;
      cfg_q.camera    <= '0;
      cfg_q.ambient   <= '0;
      cfg_q.diffuse   <= '0;
      cfg_q.specular  <= '0;
      cfg_q.shininess <= psh_pkg::SHIN_W'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psh_pkg::REG_LIGHT:     cfg_q.light     <= cfg_data_i[3*NRM_W-1:0];
        psh_pkg::REG_CAMERA:    cfg_q.camera    <= cfg_data_i[3*PNT_W-1:0];
        psh_pkg::REG_AMBIENT:   cfg_q.ambient   <= cfg_data_i;
        psh_pkg::REG_DIFFUSE:   cfg_q.diffuse   <= cfg_data_i;
        psh_pkg::REG_SPECULAR:  cfg_q.specular  <= cfg_data_i;
        psh_pkg::REG_SHININESS: cfg_q.shininess <= cfg_data_i[psh_pkg::SHIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished pixel waits at the output.
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Unpack the input transfer.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nrm[a] = s_axis_tdata_i[a*NRM_W +: NRM_W];
      pnt[a] = s_axis_tdata_i[3*NRM_W + a*PNT_W +: PNT_W];
    end
  end

  psh_geom u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .missed_i (s_axis_tuser_i),
    .nrm_i    (nrm),
    .pnt_i    (pnt),
    .cfg_i    (cfg_q),
    .valid_o  (g_valid),
    .side_o   (g_side),
    .dot_o    (g_dot),
    .sq_o     (g_sq)
  );

  psh_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_valid),
    .side_i  (g_side),
    .dot_i   (g_dot),
    .sq_i    (g_sq),
    .valid_o (s_valid),
    .side_o  (s_side),
    .dot_o   (s_dot),
    .root_o  (s_root)
  );

  psh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .side_i  (s_side),
    .dot_i   (s_dot),
    .root_i  (s_root),
    .valid_o (d_valid),
    .side_o  (d_side),
    .quo_o   (d_quo)
  );

  psh_shade #(
    .POW_TABLE_BITS (POW_TABLE_BITS)
  ) u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .side_i  (d_side),
    .quo_i   (d_quo),
    .cfg_i   (cfg_q),
    .valid_o (m_axis_tvalid_o),
    .pix_o   (pix)
  );

  assign m_axis_tdata_o = pix;

  // A waiting pixel must hold off new hits.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while the output is stalled");

  // With the output free, an offered hit is always taken.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("hit refused while the pipeline can advance");

endmodule
